>>> design/rsrg_pkg.sv
// Shared constants for the replacement-selection run generator.
// No dependencies; imported by the record and limit channel interfaces, the top level and the bench.
package rsrg_pkg;

	localparam int LIMIT_W = 5;
	localparam logic [LIMIT_W-1:0] LIMIT_RESET = 5'd16;

	localparam int MODE_W = 1;
	localparam logic [MODE_W-1:0] MODE_PUSH  = 1'b0;
	localparam logic [MODE_W-1:0] MODE_DRAIN = 1'b1;

endpackage

>>> design/rsrg_if.sv
// Valid/ready channel interfaces: record input, result output, limit register write.
// Depends on rsrg_pkg.
interface rsrg_rec_if import rsrg_pkg::*; #(
	parameter int KEY_W     = 32,
	parameter int PAYLOAD_W = 32
) ();
	logic                 valid;
	logic                 ready;
	logic [MODE_W-1:0]    mode;
	logic [KEY_W-1:0]     record_key;
	logic [PAYLOAD_W-1:0] record_payload;

	modport source (output valid, mode, record_key, record_payload, input ready);
	modport sink   (input valid, mode, record_key, record_payload, output ready);
endinterface

interface rsrg_res_if #(
	parameter int KEY_W     = 32,
	parameter int PAYLOAD_W = 32,
	parameter int TAPE_W    = 2
) ();
	logic                 valid;
	logic                 ready;
	logic [KEY_W-1:0]     out_key;
	logic [PAYLOAD_W-1:0] out_payload;
	logic [TAPE_W-1:0]    tape_index;
	logic                 last_of_run;

	modport source (output valid, out_key, out_payload, tape_index, last_of_run,
		input ready);
	modport sink   (input valid, out_key, out_payload, tape_index, last_of_run,
		output ready);
endinterface

interface rsrg_cfg_if import rsrg_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [LIMIT_W-1:0] data;

	modport source (output valid, data, input ready);
	modport sink   (input valid, data, output ready);
endinterface

>>> design/replacement_selection_run_generator.sv
// Replacement-selection run generator: top level with entry store and scan sequencer.
// Depends on rsrg_pkg and the channel interfaces in rsrg_if.sv.
//
// Usage:
//   records : mode, record_key, record_payload. Push (mode 0) or drain (mode 1).
//   results : out_key, out_payload, tape_index, last_of_run; zero or one per record.
//   cfg     : heap_limit write, always ready; write only while the block is idle.
// A push while fewer than the effective heap_limit (0 read as 1, capped at HEAP_DEPTH)
// entries are held is stored without a scan and gives no result. Any other push,
// or a drain, scans the held entries one per cycle through a single (mark, key,
// payload) comparator reading the entry memory, then emits the smallest entry and
// updates the store. A drain on an empty store gives no result.
// Marks live in the entry memory as a run-parity tag, so closing a run clears
// all of them by flipping the parity bit.
// records.ready is high only while the sequencer is idle. A result sits in an
// output register; the next item may be accepted and scanned while it waits, and
// the sequencer holds at its final step until that register is free.
// Reset empties the store, selects tape 0 and sets heap_limit to 16. No clearing
// pass is needed.
module replacement_selection_run_generator import rsrg_pkg::*; #(
	parameter int HEAP_DEPTH    = 16,
	parameter int TAPE_COUNT    = 4,
	parameter int KEY_WIDTH     = 32,
	parameter int PAYLOAD_WIDTH = 32
) (
	input  logic       clk,
	input  logic       arst_n,
	rsrg_rec_if.sink   records,
	rsrg_res_if.source results,
	rsrg_cfg_if.sink   cfg
);

	localparam int AW      = $clog2(HEAP_DEPTH);
	localparam int CNT_W   = $clog2(HEAP_DEPTH + 1);
	localparam int LW      = (CNT_W > LIMIT_W) ? CNT_W : LIMIT_W;
	localparam int TAPE_W  = (TAPE_COUNT > 1) ? $clog2(TAPE_COUNT) : 1;
	localparam int ENTRY_W = 1 + KEY_WIDTH + PAYLOAD_WIDTH;

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_DONE = 2'd2;

	logic [1:0]               state_q;
	logic [LIMIT_W-1:0]       limit_q;
	logic [CNT_W-1:0]         count_q;
	logic [CNT_W-1:0]         unmarked_q;
	logic                     parity_q;
	logic [TAPE_W-1:0]        tape_q;

	logic [MODE_W-1:0]        mode_q;
	logic [KEY_WIDTH-1:0]     key_q;
	logic [PAYLOAD_WIDTH-1:0] payload_q;

	logic [ENTRY_W-1:0]       mem [HEAP_DEPTH];
	logic [CNT_W-1:0]         rd_idx_q;
	logic [ENTRY_W-1:0]       rd_data_s1;
	logic                     rd_vld_s1;
	logic [CNT_W-1:0]         rd_idx_s1;

	logic [ENTRY_W-1:0]       best_q;   // {effective mark, key, payload}
	logic [AW-1:0]            best_idx_q;
	logic [ENTRY_W-1:0]       last_q;   // raw entry at count - 1

	logic                     out_valid_q;
	logic [KEY_WIDTH-1:0]     out_key_q;
	logic [PAYLOAD_WIDTH-1:0] out_payload_q;
	logic [TAPE_W-1:0]        out_tape_q;
	logic                     out_last_q;

	logic [LW-1:0]            lim_raw;
	logic [LW-1:0]            lim_eff;
	logic                     in_xfer;
	logic                     do_insert;
	logic                     do_scan;
	logic                     scan_issue;
	logic [ENTRY_W-1:0]       cand;
	logic                     cand_wins;
	logic                     scan_end;
	logic                     done_go;
	logic                     new_mark;
	logic                     best_unm;
	logic [CNT_W-1:0]         count_new;
	logic [CNT_W-1:0]         unmarked_new;
	logic                     run_done;
	logic                     wr_en;
	logic [AW-1:0]            wr_addr;
	logic [ENTRY_W-1:0]       wr_data;
	logic [KEY_WIDTH-1:0]     best_key;
	logic [PAYLOAD_WIDTH-1:0] best_payload;

	always_comb begin
		lim_raw = LW'(limit_q);
		if (lim_raw == '0) begin
			lim_eff = LW'(1);
		end else if (lim_raw > LW'(HEAP_DEPTH)) begin
			lim_eff = LW'(HEAP_DEPTH);
		end else begin
			lim_eff = lim_raw;
		end
	end

	assign records.ready = (state_q == ST_IDLE);
	assign cfg.ready     = 1'b1;
	assign in_xfer       = records.valid && records.ready;
	assign do_insert     = in_xfer && (records.mode == MODE_PUSH)
		&& (LW'(count_q) < lim_eff);
	assign do_scan       = in_xfer && !do_insert && (count_q != '0);

	assign scan_issue = (state_q == ST_SCAN) && (rd_idx_q != count_q);
	assign cand       = {rd_data_s1[ENTRY_W-1] ^ parity_q, rd_data_s1[ENTRY_W-2:0]};
	assign cand_wins  = (rd_idx_s1 == '0) || (cand < best_q);
	assign scan_end   = rd_vld_s1 && (rd_idx_s1 == count_q - CNT_W'(1));

	assign best_key     = best_q[ENTRY_W-2 -: KEY_WIDTH];
	assign best_payload = best_q[PAYLOAD_WIDTH-1:0];
	assign best_unm     = !best_q[ENTRY_W-1];

	assign done_go  = (state_q == ST_DONE) && (!out_valid_q || results.ready);
	assign new_mark = key_q < best_key;

	always_comb begin
		if (mode_q == MODE_PUSH) begin
			count_new    = count_q;
			unmarked_new = unmarked_q - CNT_W'(best_unm) + CNT_W'(!new_mark);
		end else begin
			count_new    = count_q - CNT_W'(1);
			unmarked_new = unmarked_q - CNT_W'(best_unm);
		end
		run_done = (count_new == '0) || (unmarked_new == '0);
	end

	always_comb begin
		wr_en   = 1'b0;
		wr_addr = count_q[AW-1:0];
		wr_data = {parity_q, records.record_key, records.record_payload};
		if (do_insert) begin
			wr_en = 1'b1;
		end else if (done_go) begin
			wr_en   = 1'b1;
			wr_addr = best_idx_q;
			if (mode_q == MODE_PUSH) begin
				wr_data = {parity_q ^ new_mark, key_q, payload_q};
			end else begin
				wr_data = last_q;
			end
		end
	end

	// entry memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data_s1 <= mem[rd_idx_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (do_scan) begin
			mode_q    <= records.mode;
			key_q     <= records.record_key;
			payload_q <= records.record_payload;
		end
		if (rd_vld_s1 && cand_wins) begin
			best_q     <= cand;
			best_idx_q <= rd_idx_s1[AW-1:0];
		end
		if (scan_end) begin
			last_q <= rd_data_s1;
		end
		if (done_go) begin
			out_key_q     <= best_key;
			out_payload_q <= best_payload;
			out_tape_q    <= tape_q;
			out_last_q    <= run_done;
		end
		rd_idx_s1 <= rd_idx_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			limit_q     <= LIMIT_RESET;
			count_q     <= '0;
			unmarked_q  <= '0;
			parity_q    <= 1'b0;
			tape_q      <= '0;
			rd_idx_q    <= '0;
			rd_vld_s1   <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				limit_q <= cfg.data;
			end
			rd_vld_s1 <= scan_issue;
			if (done_go) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (do_insert) begin
						count_q    <= count_q + CNT_W'(1);
						unmarked_q <= unmarked_q + CNT_W'(1);
					end else if (do_scan) begin
						rd_idx_q <= '0;
						state_q  <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						rd_idx_q <= rd_idx_q + CNT_W'(1);
					end
					if (scan_end) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (done_go) begin
						count_q <= count_new;
						if (run_done) begin
							parity_q   <= !parity_q;
							unmarked_q <= count_new;
							if (tape_q == TAPE_W'(TAPE_COUNT - 1)) begin
								tape_q <= '0;
							end else begin
								tape_q <= tape_q + TAPE_W'(1);
							end
						end else begin
							unmarked_q <= unmarked_new;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign results.valid       = out_valid_q;
	assign results.out_key     = out_key_q;
	assign results.out_payload = out_payload_q;
	assign results.tape_index  = out_tape_q;
	assign results.last_of_run = out_last_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(HEAP_DEPTH))
		else $error("entry count beyond store depth");

	a_unmarked_bound: assert property (@(posedge clk) disable iff (!arst_n)
		unmarked_q <= count_q)
		else $error("unmarked count exceeds entry count");

	a_scan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |-> (rd_idx_q <= count_q) && (count_q != '0))
		else $error("scan index out of range");

	a_result_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == ST_DONE))
		else $error("result loaded outside final step");

	a_count_step: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SCAN) |=> ($stable(count_q) && $stable(parity_q)))
		else $error("store state changed during scan");

endmodule

>>> dv/testbench.sv
// Self-checking bench for replacement_selection_run_generator: a run scoreboard predicts
// emitted records, tape and run ends; tasks drive records and limit writes.
// Depends on rsrg_pkg, the channel interfaces in rsrg_if.sv and the top level RTL.
`timescale 1ns / 100ps

module testbench import rsrg_pkg::*;;

	localparam int HEAP_DEPTH = 16;
	localparam int TAPE_COUNT = 4;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLDOFF_CYCLES = 300;
	localparam int PHASE_ITEMS = 123;
	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [31:0] key;
		logic [31:0] payload;
		logic [1:0]  tape;
		logic        run_end;
	} run_record_t;

	typedef enum int {KEYS_WIDE, KEYS_NARROW, KEYS_RAMP, KEYS_EDGE} key_style_t;

	class run_scoreboard;
		logic [31:0]      keys [HEAP_DEPTH];
		logic [31:0]      pays [HEAP_DEPTH];
		bit               marked [HEAP_DEPTH];
		int unsigned      held;
		int unsigned      tape;
		logic [LIMIT_W-1:0] limit;
		run_record_t      expected_q [$];
		int unsigned      errors, checked, runs_closed, settings;

		function new();
			held = 0;
			tape = 0;
			limit = LIMIT_RESET;
			foreach (marked[i]) marked[i] = 1'b0;
		endfunction

		function void set_limit(logic [LIMIT_W-1:0] value);
			limit = value;
			settings++;
		endfunction

		function int active_limit();
			if (limit == 0)
				return 1;
			if (limit > HEAP_DEPTH)
				return HEAP_DEPTH;
			return limit;
		endfunction

		// order: unmarked first, then key, then payload
		function bit precedes(int a, int b);
			if (marked[a] != marked[b])
				return !marked[a];
			if (keys[a] != keys[b])
				return keys[a] < keys[b];
			return pays[a] < pays[b];
		endfunction

		function int smallest();
			int best;
			best = 0;
			for (int i = 1; i < held; i++)
				if (precedes(i, best))
					best = i;
			return best;
		endfunction

		// returns 1 unless the transfer was a drain on an empty store
		function bit note_record(logic mode, logic [31:0] key, logic [31:0] payload);
			int slot, tail;
			run_record_t res;
			if (mode == MODE_PUSH && held < active_limit()) begin
				keys[held] = key;
				pays[held] = payload;
				marked[held] = 1'b0;
				held++;
				return 1'b1;
			end
			if (held == 0)
				return 1'b0;
			slot = smallest();
			res.key = keys[slot];
			res.payload = pays[slot];
			res.tape = tape[1:0];
			if (mode == MODE_PUSH) begin
				marked[slot] = key < keys[slot];
				keys[slot] = key;
				pays[slot] = payload;
			end else begin
				tail = held - 1;
				keys[slot] = keys[tail];
				pays[slot] = pays[tail];
				marked[slot] = marked[tail];
				marked[tail] = 1'b0;
				held = tail;
			end
			res.run_end = (held == 0) || marked[smallest()];
			if (res.run_end) begin
				foreach (marked[i]) marked[i] = 1'b0;
				tape = (tape + 1) % TAPE_COUNT;
				runs_closed++;
			end
			expected_q.push_back(res);
			return 1'b1;
		endfunction

		function void check_result(logic [31:0] key, logic [31:0] payload,
				logic [1:0] tape_idx, logic run_end);
			run_record_t want;
			checked++;
			if (expected_q.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("unexpected result: key=%h payload=%h tape=%0d last=%0b",
						key, payload, tape_idx, run_end);
				return;
			end
			want = expected_q.pop_front();
			if (key !== want.key || payload !== want.payload || tape_idx !== want.tape ||
					run_end !== want.run_end) begin
				errors++;
				if (errors <= 10) begin
					$write("result %0d: expected key=%h payload=%h tape=%0d last=%0b, ",
						checked, want.key, want.payload, want.tape, want.run_end);
					$display("got key=%h payload=%h tape=%0d last=%0b",
						key, payload, tape_idx, run_end);
				end
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;

	rsrg_rec_if rec_ch ();
	rsrg_res_if res_ch ();
	rsrg_cfg_if cfg_ch ();

	replacement_selection_run_generator DUT (
		.clk    (clk),
		.arst_n (arst_n),
		.records(rec_ch),
		.results(res_ch),
		.cfg    (cfg_ch)
	);

	run_scoreboard board = new();
	int unsigned records_sent = 0;
	int unsigned cycle_count = 0;
	int          sink_stall = 0;
	bit          idle_on = 1'b1;
	bit          pressure_on = 1'b0;
	logic        hold_results = 1'b0;
	logic [31:0] ramp_key = 32'h0000_1000;
	int          limit_plan [10] = '{31, 1, 4, 16, 0, 9, 2, 16, 0, 12};

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic logic [31:0] draw_key(key_style_t style);
		case (style)
			KEYS_NARROW: return $urandom_range(0, 15);
			KEYS_RAMP: begin
				ramp_key += $urandom_range(0, 64);
				if ($urandom_range(0, 7) == 0)
					ramp_key -= $urandom_range(0, 512);
				return ramp_key;
			end
			KEYS_EDGE: begin
				case ($urandom_range(0, 3))
					0: return 32'h0000_0000;
					1: return 32'hFFFF_FFFF;
					2: return 32'h8000_0000;
					default: return $urandom_range(0, 1) ? 32'h0000_0001 : 32'hFFFF_FFFE;
				endcase
			end
			default: return $urandom();
		endcase
	endfunction

	function automatic logic [31:0] draw_payload(key_style_t style);
		if (style == KEYS_NARROW || style == KEYS_EDGE)
			return $urandom_range(0, 3);
		return $urandom();
	endfunction

	task automatic send_record(logic mode, logic [31:0] key, logic [31:0] payload);
		int gap;
		gap = (idle_on && !pressure_on && $urandom_range(0, 5) == 0) ?
			$urandom_range(1, 11) : 0;
		if (gap > 0) begin
			rec_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		rec_ch.valid <= 1'b1;
		rec_ch.mode <= mode;
		rec_ch.record_key <= key;
		rec_ch.record_payload <= payload;
		do @(posedge clk); while (!rec_ch.ready);
		if (board.note_record(mode, key, payload))
			records_sent++;
	endtask

	// stop offering, let all results drain, then give the sequencer time to finish
	task automatic wait_idle();
		rec_ch.valid <= 1'b0;
		while (board.expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_limit(logic [LIMIT_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		cfg_ch.valid <= 1'b0;
		board.set_limit(value);
	endtask

	task automatic run_phase(int unsigned items);
		int unsigned phase_end;
		int kind, n;
		key_style_t style;
		phase_end = records_sent + items;
		while (records_sent < phase_end) begin
			kind = $urandom_range(0, 9);
			style = key_style_t'($urandom_range(0, 3));
			if (kind < 7) begin
				n = $urandom_range(1, 2 * board.active_limit() + 8);
				repeat (n) send_record(MODE_PUSH, draw_key(style), draw_payload(style));
				if ($urandom_range(0, 1)) begin
					n = board.held + $urandom_range(0, 1);
					repeat (n) send_record(MODE_DRAIN, $urandom(), $urandom());
				end
			end else if (kind < 9) begin
				repeat ($urandom_range(1, 4))
					send_record(1'($urandom_range(0, 1)), draw_key(style), draw_payload(style));
			end else begin
				repeat ($urandom_range(1, 5)) send_record(MODE_DRAIN, $urandom(), $urandom());
			end
		end
	endtask

	// result sink: checks every transfer, stalls in random bursts or on long hold-off
	initial begin
		res_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (res_ch.valid && res_ch.ready)
				board.check_result(res_ch.out_key, res_ch.out_payload, res_ch.tape_index,
					res_ch.last_of_run);
			if (hold_results || sink_stall > 0) begin
				res_ch.ready <= 1'b0;
				if (sink_stall > 0)
					sink_stall--;
			end else if (idle_on && $urandom_range(0, 9) == 0) begin
				sink_stall = $urandom_range(1, 11) - 1;
				res_ch.ready <= 1'b0;
			end else begin
				res_ch.ready <= 1'b1;
			end
		end
	end

	// long receiver hold-off so the store fills and the record input stalls
	initial begin
		wait (pressure_on);
		hold_results <= 1'b1;
		repeat (HOLDOFF_CYCLES) @(posedge clk);
		hold_results <= 1'b0;
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding", cycle_count,
			board.expected_q.size());
		$display("[FAIL] regression broken");
		$finish;
	end

	initial begin
		arst_n <= 1'b0;
		rec_ch.valid <= 1'b0;
		rec_ch.mode <= MODE_PUSH;
		rec_ch.record_key <= '0;
		rec_ch.record_payload <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: empty drain, extremes, tie on key, marking, run close, drain to empty
		send_record(MODE_DRAIN, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		wait_idle();
		write_limit(5'd3);
		send_record(MODE_DRAIN, 32'h0, 32'h0);
		send_record(MODE_PUSH, 32'hFFFF_FFFF, 32'h0000_0000);
		send_record(MODE_PUSH, 32'h0000_0000, 32'hFFFF_FFFF);
		send_record(MODE_PUSH, 32'h0000_0005, 32'h0000_0001);
		send_record(MODE_PUSH, 32'h0000_0005, 32'h0000_0000);
		send_record(MODE_PUSH, 32'h0000_0000, 32'h0000_0007);
		send_record(MODE_PUSH, 32'h0000_0005, 32'h0000_0002);
		send_record(MODE_PUSH, 32'h0000_0001, 32'h8000_0000);
		send_record(MODE_PUSH, 32'hFFFF_FFFF, 32'h0000_0003);
		send_record(MODE_PUSH, 32'h0000_0002, 32'h5555_5555);
		repeat (4) send_record(MODE_DRAIN, 32'hAAAA_AAAA, 32'h5555_5555);
		wait_idle();
		write_limit(5'd0);
		send_record(MODE_PUSH, 32'h0000_0010, 32'h1);
		send_record(MODE_PUSH, 32'h0000_0008, 32'h2);
		send_record(MODE_PUSH, 32'h0000_0020, 32'h3);
		repeat (2) send_record(MODE_DRAIN, 32'h0, 32'h0);

		limit_plan[8] = $urandom_range(0, 31);
		foreach (limit_plan[p]) begin
			wait_idle();
			write_limit(limit_plan[p][LIMIT_W-1:0]);
			pressure_on = (p == 2);
			idle_on = (p != $size(limit_plan) - 1);
			run_phase(PHASE_ITEMS);
		end
		pressure_on = 1'b0;
		wait_idle();

		$write("%0d records sent over %0d limit settings; ", records_sent, board.settings);
		$display("%0d results checked, %0d runs closed", board.checked, board.runs_closed);
		$display("%0d mismatches, %0d results never seen", board.errors,
			board.expected_q.size());
		if (board.errors == 0 && board.expected_q.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
